### rtl/core/blls_pkg.sv
// ----------------------------------------------------------------------------
// blls_pkg: shared types for the Bresenham line stepper
// Coordinate, error-term and line-command types used by the front end, the
// command queue and the pixel stepper.
// ----------------------------------------------------------------------------
package blls_pkg;

  // Width of every coordinate port; narrower rasters mask inside the block.
  localparam int unsigned FieldW = 6;
  // The error term stays within about twice the longest delta, and the
  // doubled term needs one bit more.
  localparam int unsigned ErrW   = FieldW + 3;
  localparam int unsigned QDepth = 2;

  typedef logic [FieldW-1:0]        coord_t;
  typedef logic signed [ErrW-1:0]   err_t;

  // One classified line, ready for the stepper.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t ex;
    coord_t ey;
    coord_t dx;
    coord_t dy;
    logic   x_neg;
    logic   y_neg;
    err_t   err;
  } line_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic {
    BackIdle,
    BackRun
  } back_state_e;

endpackage

### rtl/core/blls_front.sv
// ----------------------------------------------------------------------------
// blls_front: line setup
// Masks the endpoints to the raster, derives deltas, directions and the
// initial error term, and drops lines whose endpoints coincide.
// ----------------------------------------------------------------------------
module blls_front #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                 start_i,
  input  logic                 busy_i,
  input  blls_pkg::coord_t     start_x_i,
  input  blls_pkg::coord_t     start_y_i,
  input  blls_pkg::coord_t     end_x_i,
  input  blls_pkg::coord_t     end_y_i,
  output logic                 push_o,
  output blls_pkg::line_cmd_t  cmd_o
);
  import blls_pkg::*;

  localparam coord_t CoordMask = coord_t'((1 << COORD_BITS) - 1);

  coord_t x, y, ex, ey, dx, dy;
  err_t   dx_ext, dy_ext;

  always_comb begin
    x  = start_x_i & CoordMask;
    y  = start_y_i & CoordMask;
    ex = end_x_i & CoordMask;
    ey = end_y_i & CoordMask;
    dx = (x < ex) ? (ex - x) : (x - ex);
    dy = (y < ey) ? (ey - y) : (y - ey);
    dx_ext = err_t'({{(ErrW - FieldW){1'b0}}, dx});
    dy_ext = err_t'({{(ErrW - FieldW){1'b0}}, dy});

    cmd_o.x     = x;
    cmd_o.y     = y;
    cmd_o.ex    = ex;
    cmd_o.ey    = ey;
    cmd_o.dx    = dx;
    cmd_o.dy    = dy;
    cmd_o.x_neg = !(x < ex);
    cmd_o.y_neg = !(y < ey);
    cmd_o.err   = dx_ext - dy_ext;

    // A line whose endpoints coincide has no pixels at all.
    push_o = start_i && !busy_i && ((x != ex) || (y != ey));
  end

endmodule

### rtl/core/blls_queue.sv
// ----------------------------------------------------------------------------
// blls_queue: line command queue
// Small FIFO that decouples line setup from pixel stepping.
// ----------------------------------------------------------------------------
module blls_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  blls_pkg::line_cmd_t    cmd_i,
  input  logic                   pop_i,
  output blls_pkg::line_cmd_t    cmd_o,
  output blls_pkg::queue_stat_t  stat_o
);
  import blls_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  line_cmd_t         mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

### rtl/core/blls_back.sv
// ----------------------------------------------------------------------------
// blls_back: pixel stepper
// Walks one line a pixel per cycle and marks the pixel before the end point.
// ----------------------------------------------------------------------------
module blls_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  blls_pkg::queue_stat_t  stat_i,
  input  blls_pkg::line_cmd_t    cmd_i,
  output logic                   pop_o,
  output logic                   pix_valid_o,
  output blls_pkg::coord_t       pix_x_o,
  output blls_pkg::coord_t       pix_y_o,
  output logic                   last_pixel_o
);
  import blls_pkg::*;

  back_state_e state_q, state_d;
  line_cmd_t   cur_q, cur_d;

  err_t   e2, dx_ext, dy_ext;
  logic   step_x, step_y, last;
  coord_t nx, ny;

  always_comb begin
    dx_ext = err_t'({{(ErrW - FieldW){1'b0}}, cur_q.dx});
    dy_ext = err_t'({{(ErrW - FieldW){1'b0}}, cur_q.dy});
    e2     = cur_q.err <<< 1;
    step_x = e2 > -dy_ext;
    step_y = e2 < dx_ext;
    nx     = step_x ? (cur_q.x_neg ? cur_q.x - 1'b1 : cur_q.x + 1'b1) : cur_q.x;
    ny     = step_y ? (cur_q.y_neg ? cur_q.y - 1'b1 : cur_q.y + 1'b1) : cur_q.y;
    last   = (nx == cur_q.ex) && (ny == cur_q.ey);
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          cur_d   = cmd_i;
          state_d = BackRun;
        end
      end
      BackRun: begin
        cur_d.x   = nx;
        cur_d.y   = ny;
        cur_d.err = cur_q.err - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
        if (last) begin
          if (!stat_i.empty) begin
            pop_o = 1'b1;
            cur_d = cmd_i;
          end else begin
            state_d = BackIdle;
          end
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign pix_valid_o  = (state_q == BackRun);
  assign pix_x_o      = cur_q.x;
  assign pix_y_o      = cur_q.y;
  assign last_pixel_o = pix_valid_o && last;

endmodule

### rtl/core/bresenham_line_stepper_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top: all-octant Bresenham line stepper
// Turns a start point and an end point into a stream of pixel coordinates.
// ----------------------------------------------------------------------------
// A line item is taken at a rising edge where start is high and busy is
// low. The block emits the start pixel and every following pixel of the line,
// stopping just short of the end point, which is never drawn; an item whose
// endpoints coincide produces nothing. Each pixel appears for exactly one
// cycle with pix_valid_o high, and the final pixel of a line carries
// last_pixel_o. The receiver cannot stall the block, so it must take a pixel
// in every cycle that pix_valid_o is high. The stepper walks a line one pixel
// per cycle, and a line has up to 2^COORD_BITS - 1 pixels; that single-pixel
// loop in the stepper sets the throughput. An idle stepper first loads the
// line from the queue: the accepting edge writes the queue entry, the stepper
// then copies it into its current-line register, and that register drives
// the first pixel onto the result ports without further logic. A
// two-entry queue sits between setup and stepping, so busy rises only when
// two lines wait behind the one being drawn; while the stepper is busy, the
// next queued line starts in the cycle right after the last pixel.
// With COORD_BITS below 6, only the low COORD_BITS bits of each input
// coordinate are used.
module bresenham_line_stepper_top #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  blls_pkg::coord_t  start_x_i,
  input  blls_pkg::coord_t  start_y_i,
  input  blls_pkg::coord_t  end_x_i,
  input  blls_pkg::coord_t  end_y_i,
  output logic              pix_valid_o,
  output blls_pkg::coord_t  pix_x_o,
  output blls_pkg::coord_t  pix_y_o,
  output logic              last_pixel_o
);
  import blls_pkg::*;

  logic        push, pop;
  line_cmd_t   push_cmd, pop_cmd;
  queue_stat_t q_stat;

  // Setup: masking, deltas, directions and the initial error term.
  blls_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .start_i   (start),
    .busy_i    (busy),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Lines waiting for the stepper.
  blls_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .stat_o (q_stat)
  );

  // Pixel walk, one pixel per cycle.
  blls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_i       (q_stat),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .pix_valid_o  (pix_valid_o),
    .pix_x_o      (pix_x_o),
    .pix_y_o      (pix_y_o),
    .last_pixel_o (last_pixel_o)
  );

  // New items are refused only while the queue is full.
  assign busy = q_stat.full;

endmodule

### rtl/core/blls_checker.sv
// ----------------------------------------------------------------------------
// blls_checker: port-level checks for the line stepper
// Watches the top-level ports for line continuity and handshake sanity.
// ----------------------------------------------------------------------------
module blls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input blls_pkg::coord_t  pix_x_o,
  input blls_pkg::coord_t  pix_y_o,
  input logic              pix_valid_o,
  input logic              last_pixel_o
);
  import blls_pkg::*;

  coord_t px_q, py_q;
  coord_t ddx, ddy;
  logic   adj_x, adj_y;

  always_ff @(posedge clk_i) begin
    px_q <= pix_x_o;
    py_q <= pix_y_o;
  end

  assign ddx   = pix_x_o - px_q;
  assign ddy   = pix_y_o - py_q;
  assign adj_x = (ddx == '0) || (ddx == coord_t'(1)) || (ddx == '1);
  assign adj_y = (ddy == '0) || (ddy == coord_t'(1)) || (ddy == '1);

  // Within a line the stepper emits every cycle, each pixel a neighbor of
  // the previous one.
  a_line_continuous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && !last_pixel_o |=>
      pix_valid_o && adj_x && adj_y && ((ddx != '0) || (ddy != '0)))
    else $error("line pixels not contiguous");

  // The queue fills only by taking an item.
  a_busy_by_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  // The last flag only marks a valid pixel.
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_pixel_o |-> pix_valid_o)
    else $error("last flag without a pixel");

  // Nothing is emitted and busy is low in the first cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !pix_valid_o && !busy)
    else $error("activity right after reset");

endmodule

bind bresenham_line_stepper_top blls_checker u_blls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .pix_x_o      (pix_x_o),
  .pix_y_o      (pix_y_o),
  .pix_valid_o  (pix_valid_o),
  .last_pixel_o (last_pixel_o)
);
